/* sv/pbal_pkg.sv */
package pbal_pkg;

    localparam int unsigned FRAME_COUNT_DEF   = 3;
    localparam int unsigned MAX_ALIGNMENT_DEF = 512;
    localparam int unsigned QUEUE_DEPTH       = 2;

    localparam int unsigned IDX_W    = 2;
    localparam int unsigned SIZE_W   = 31;
    localparam int unsigned ALIGN_W  = 11;
    localparam int unsigned OFFSET_W = 32;

    localparam logic [SIZE_W-1:0] SIZE_LIMIT = 31'h4000_0000;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_READY   = 3'd1,
        ST_BAD_ALIGN   = 3'd2,
        ST_OVERFLOW    = 3'd3,
        ST_FRAME_BEGUN = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        K_ALLOC     = 2'd0,
        K_BEGIN     = 2'd1,
        K_REJ_SIZE  = 2'd2,
        K_REJ_ALIGN = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [OFFSET_W-1:0] base;
        logic [SIZE_W-1:0]   size;
        logic [ALIGN_W-1:0]  mask;
    } entry_t;

endpackage

/* sv/per_frame_aligned_bump_allocator_unit.sv */
// Per-frame bump allocator over a ring of FRAME_COUNT equal slices.
// Config channel (cfg_valid/cfg_ready/cfg_bytes_per_frame): slice size in
// bytes, clamped to 1 GiB and rounded up to MAX_ALIGNMENT; zero = not ready.
// Write it only while no word is in flight. cfg_ready is always high.
// Request channel (s_*): begin frame selects a slice and clears the fill;
// allocate returns an aligned absolute offset or a failure status.
// Result channel (m_*): one word per request, in order, carrying status,
// offset, first-overflow flag and peak fill.
// Throughput is one word per cycle while the result register is free or
// m_ready is high, set by the combinational align/add/compare on the running
// fill in the back end. A two-word queue sits between classifier and back end
// and a result register on the output; while m_ready is low the result holds,
// the queue fills and then s_ready drops.
// Reset (aresetn low, synchronous) empties the queue, drops m_valid and clears
// slice size, frame base, fill, peak and the overflow flag.
module per_frame_aligned_bump_allocator_unit #(
    parameter int unsigned FRAME_COUNT   = pbal_pkg::FRAME_COUNT_DEF,
    parameter int unsigned MAX_ALIGNMENT = pbal_pkg::MAX_ALIGNMENT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pbal_pkg::SIZE_W-1:0]    cfg_bytes_per_frame,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_operation,
    input  logic [pbal_pkg::IDX_W-1:0]     s_frame_index,
    input  logic [pbal_pkg::SIZE_W-1:0]    s_request_size,
    input  logic [pbal_pkg::ALIGN_W-1:0]   s_request_alignment,
    output logic                           m_valid,
    input  logic                           m_ready,
    output pbal_pkg::status_t              m_status,
    output logic [pbal_pkg::OFFSET_W-1:0]  m_absolute_offset,
    output logic                           m_first_overflow,
    output logic [pbal_pkg::SIZE_W-1:0]    m_peak_bytes
);
    import pbal_pkg::*;

    logic [SIZE_W-1:0]   slice_reg, slice_next;
    logic [SIZE_W-1:0]   cfg_clamped;
    logic [OFFSET_W-1:0] cfg_rounded;

    entry_t front_entry;
    entry_t q_entry;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;

    always_comb begin
        cfg_clamped = (cfg_bytes_per_frame > SIZE_LIMIT) ? SIZE_LIMIT : cfg_bytes_per_frame;
        cfg_rounded = ({1'b0, cfg_clamped} + OFFSET_W'(MAX_ALIGNMENT - 1)) &
                      ~OFFSET_W'(MAX_ALIGNMENT - 1);
        slice_next  = (cfg_valid && cfg_ready) ? cfg_rounded[SIZE_W-1:0] : slice_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slice_reg <= '0;
        end else begin
            slice_reg <= slice_next;
        end
    end

    pbal_front #(
        .FRAME_COUNT   (FRAME_COUNT),
        .MAX_ALIGNMENT (MAX_ALIGNMENT)
    ) u_front (
        .s_operation         (s_operation),
        .s_frame_index       (s_frame_index),
        .s_request_size      (s_request_size),
        .s_request_alignment (s_request_alignment),
        .slice_bytes         (slice_reg),
        .entry               (front_entry)
    );

    pbal_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_valid && s_ready),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    pbal_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .slice_bytes       (slice_reg),
        .q_valid           (q_valid),
        .q_entry           (q_entry),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_absolute_offset (m_absolute_offset),
        .m_first_overflow  (m_first_overflow),
        .m_peak_bytes      (m_peak_bytes)
    );

endmodule

/* sv/pbal_front.sv */
module pbal_front #(
    parameter int unsigned FRAME_COUNT   = pbal_pkg::FRAME_COUNT_DEF,
    parameter int unsigned MAX_ALIGNMENT = pbal_pkg::MAX_ALIGNMENT_DEF
) (
    input  logic                           s_operation,
    input  logic [pbal_pkg::IDX_W-1:0]     s_frame_index,
    input  logic [pbal_pkg::SIZE_W-1:0]    s_request_size,
    input  logic [pbal_pkg::ALIGN_W-1:0]   s_request_alignment,
    input  logic [pbal_pkg::SIZE_W-1:0]    slice_bytes,
    output pbal_pkg::entry_t               entry
);
    import pbal_pkg::*;

    logic [IDX_W-1:0]    idx_sat;
    logic [OFFSET_W-1:0] slice_w;
    logic                align_ok;

    always_comb begin
        idx_sat = ({1'b0, s_frame_index} >= (IDX_W+1)'(FRAME_COUNT)) ?
                  IDX_W'(FRAME_COUNT - 1) : s_frame_index;
        slice_w = {1'b0, slice_bytes};

        align_ok = (s_request_alignment != '0) &&
                   ((s_request_alignment & (s_request_alignment - ALIGN_W'(1))) == '0) &&
                   (32'(s_request_alignment) <= 32'(MAX_ALIGNMENT));

        // slice times index, index is at most three
        entry.base = (idx_sat[0] ? slice_w : '0) + (idx_sat[1] ? (slice_w << 1) : '0);
        entry.size = s_request_size;
        entry.mask = s_request_alignment - ALIGN_W'(1);

        if (s_operation) begin
            entry.kind = K_BEGIN;
        end else if (slice_bytes == '0 || s_request_size == '0) begin
            entry.kind = K_REJ_SIZE;
        end else if (!align_ok) begin
            entry.kind = K_REJ_ALIGN;
        end else begin
            entry.kind = K_ALLOC;
        end
    end

endmodule

/* sv/pbal_queue.sv */
module pbal_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  pbal_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             q_valid,
    output pbal_pkg::entry_t q_entry
);
    import pbal_pkg::*;

    localparam int unsigned DEPTH = QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

/* sv/pbal_back.sv */
module pbal_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [pbal_pkg::SIZE_W-1:0]    slice_bytes,
    input  logic                           q_valid,
    input  pbal_pkg::entry_t               q_entry,
    output logic                           q_pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output pbal_pkg::status_t              m_status,
    output logic [pbal_pkg::OFFSET_W-1:0]  m_absolute_offset,
    output logic                           m_first_overflow,
    output logic [pbal_pkg::SIZE_W-1:0]    m_peak_bytes
);
    import pbal_pkg::*;

    logic [OFFSET_W-1:0] frame_base_reg, frame_base_next;
    logic [SIZE_W-1:0]   fill_reg, fill_next;
    logic [SIZE_W-1:0]   peak_reg, peak_next;
    logic                ovf_seen_reg, ovf_seen_next;

    logic                m_valid_reg, m_valid_next;
    status_t             status_reg, status_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic                first_reg, first_next;

    logic [OFFSET_W-1:0] mask_w;
    logic [OFFSET_W-1:0] aligned;
    logic [OFFSET_W-1:0] end_pos;
    logic                fits;

    assign q_pop = q_valid && (!m_valid_reg || m_ready);

    always_comb begin
        mask_w  = {{(OFFSET_W-ALIGN_W){1'b0}}, q_entry.mask};
        aligned = ({1'b0, fill_reg} + mask_w) & ~mask_w;
        end_pos = aligned + {1'b0, q_entry.size};
        fits    = (end_pos <= {1'b0, slice_bytes});

        frame_base_next = frame_base_reg;
        fill_next       = fill_reg;
        peak_next       = peak_reg;
        ovf_seen_next   = ovf_seen_reg;
        status_next     = status_reg;
        offset_next     = offset_reg;
        first_next      = first_reg;
        m_valid_next    = m_ready ? 1'b0 : m_valid_reg;

        if (q_pop) begin
            m_valid_next = 1'b1;
            offset_next  = '0;
            first_next   = 1'b0;
            unique case (q_entry.kind)
                K_BEGIN: begin
                    frame_base_next = q_entry.base;
                    fill_next       = '0;
                    ovf_seen_next   = 1'b0;
                    status_next     = ST_FRAME_BEGUN;
                    offset_next     = q_entry.base;
                end
                K_REJ_SIZE: begin
                    status_next = ST_NOT_READY;
                end
                K_REJ_ALIGN: begin
                    status_next = ST_BAD_ALIGN;
                end
                K_ALLOC: begin
                    if (fits) begin
                        status_next = ST_OK;
                        offset_next = frame_base_reg + aligned;
                        fill_next   = end_pos[SIZE_W-1:0];
                        if (end_pos[SIZE_W-1:0] > peak_reg) begin
                            peak_next = end_pos[SIZE_W-1:0];
                        end
                    end else begin
                        status_next   = ST_OVERFLOW;
                        first_next    = !ovf_seen_reg;
                        ovf_seen_next = 1'b1;
                    end
                end
                default: begin
                    status_next = ST_NOT_READY;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_base_reg <= '0;
            fill_reg       <= '0;
            peak_reg       <= '0;
            ovf_seen_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            frame_base_reg <= frame_base_next;
            fill_reg       <= fill_next;
            peak_reg       <= peak_next;
            ovf_seen_reg   <= ovf_seen_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // output word, no reset needed
    logic [SIZE_W-1:0] peak_out_reg;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            status_reg   <= status_next;
            offset_reg   <= offset_next;
            first_reg    <= first_next;
            peak_out_reg <= peak_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = status_reg;
    assign m_absolute_offset = offset_reg;
    assign m_first_overflow  = first_reg;
    assign m_peak_bytes      = peak_out_reg;

    a_peak_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (peak_reg >= $past(peak_reg)))
        else $error("peak fill went down");

    a_first_is_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && first_reg) |-> (status_reg == ST_OVERFLOW))
        else $error("first overflow flag without overflow status");

    a_grant_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_entry.kind == K_ALLOC && fits) |=>
            (offset_reg >= $past(frame_base_reg)))
        else $error("granted offset below frame base");

endmodule

/* tb/tb_per_frame_aligned_bump_allocator_unit.sv */
module tb_per_frame_aligned_bump_allocator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import pbal_pkg::*;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_BEGIN = 1'b1;
    localparam int unsigned FRAMES = FRAME_COUNT_DEF;
    localparam int unsigned MAX_ALIGN = MAX_ALIGNMENT_DEF;
    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned HOLD_CYCLES = 80;

    typedef struct packed {
        status_t             status;
        logic [OFFSET_W-1:0] offset;
        logic                first_ovf;
        logic [SIZE_W-1:0]   peak;
    } grant_t;

    class alloc_scoreboard;
        logic [SIZE_W-1:0]   bytes_cfg = '0;
        logic [OFFSET_W-1:0] base = '0;
        logic [SIZE_W-1:0]   fill = '0;
        logic [SIZE_W-1:0]   peak = '0;
        bit                  ovf_seen = 0;
        grant_t              awaited_grants[$];
        int unsigned         errors = 0;

        function void set_slice_size(logic [SIZE_W-1:0] v);
            bytes_cfg = v;
        endfunction

        function logic [63:0] slice_bytes();
            logic [63:0] v;
            v = bytes_cfg;
            if (v > SIZE_LIMIT) v = SIZE_LIMIT;
            return (v + MAX_ALIGN - 1) & ~(64'(MAX_ALIGN) - 1);
        endfunction

        function int unsigned pending();
            return awaited_grants.size();
        endfunction

        function void note_request(logic op, logic [IDX_W-1:0] idx,
                                   logic [SIZE_W-1:0] size, logic [ALIGN_W-1:0] align);
            logic [63:0] slice;
            logic [63:0] aligned;
            logic [63:0] sum;
            logic [63:0] a;
            int unsigned sel;
            grant_t g;
            slice = slice_bytes();
            a = align;
            g.status = ST_OK;
            g.offset = '0;
            g.first_ovf = 1'b0;
            if (op == OP_BEGIN) begin
                sel = (idx >= FRAMES) ? FRAMES - 1 : idx;
                sum = slice * sel;
                base = sum[31:0];
                fill = '0;
                ovf_seen = 0;
                g.status = ST_FRAME_BEGUN;
                g.offset = base;
            end else if (slice == 0 || size == 0) begin
                g.status = ST_NOT_READY;
            end else if (a == 0 || (a & (a - 1)) != 0 || a > MAX_ALIGN) begin
                g.status = ST_BAD_ALIGN;
            end else begin
                aligned = (64'(fill) + a - 1) & ~(a - 1);
                if (aligned + size > slice) begin
                    g.status = ST_OVERFLOW;
                    if (!ovf_seen) begin
                        g.first_ovf = 1'b1;
                        ovf_seen = 1;
                    end
                end else begin
                    sum = 64'(base) + aligned;
                    g.offset = sum[31:0];
                    sum = aligned + size;
                    fill = sum[SIZE_W-1:0];
                    if (fill > peak) peak = fill;
                end
            end
            g.peak = peak;
            awaited_grants.push_back(g);
        endfunction

        function void check_result(status_t st, logic [OFFSET_W-1:0] off, logic first_ovf,
                                   logic [SIZE_W-1:0] pk);
            grant_t g;
            if (awaited_grants.size() == 0) begin
                $display("%0t: unexpected result word, status %0d offset %0h", $time, st, off);
                errors++;
                return;
            end
            g = awaited_grants.pop_front();
            if (st !== g.status) begin
                $display("%0t: status expected %0d actual %0d", $time, g.status, st);
                errors++;
            end
            if (off !== g.offset) begin
                $display("%0t: offset expected %0h actual %0h", $time, g.offset, off);
                errors++;
            end
            if (first_ovf !== g.first_ovf) begin
                $display("%0t: first overflow expected %0b actual %0b", $time,
                         g.first_ovf, first_ovf);
                errors++;
            end
            if (pk !== g.peak) begin
                $display("%0t: peak expected %0h actual %0h", $time, g.peak, pk);
                errors++;
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [SIZE_W-1:0]   cfg_bytes_per_frame = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_operation = OP_ALLOC;
    logic [IDX_W-1:0]    s_frame_index = '0;
    logic [SIZE_W-1:0]   s_request_size = '0;
    logic [ALIGN_W-1:0]  s_request_alignment = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    status_t             m_status;
    logic [OFFSET_W-1:0] m_absolute_offset;
    logic                m_first_overflow;
    logic [SIZE_W-1:0]   m_peak_bytes;

    bit hold_request = 0;
    int unsigned quiet_cycles = 0;
    alloc_scoreboard sb = new();

    per_frame_aligned_bump_allocator_unit #(
        .FRAME_COUNT   (FRAMES),
        .MAX_ALIGNMENT (MAX_ALIGN)
    ) dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_bytes_per_frame (cfg_bytes_per_frame),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_operation         (s_operation),
        .s_frame_index       (s_frame_index),
        .s_request_size      (s_request_size),
        .s_request_alignment (s_request_alignment),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_absolute_offset   (m_absolute_offset),
        .m_first_overflow    (m_first_overflow),
        .m_peak_bytes        (m_peak_bytes)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_status, m_absolute_offset, m_first_overflow, m_peak_bytes);
            if (s_valid && s_ready)
                sb.note_request(s_operation, s_frame_index, s_request_size,
                                s_request_alignment);
            if (cfg_valid && cfg_ready)
                sb.set_slice_size(cfg_bytes_per_frame);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((m_valid && m_ready) || (s_valid && s_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("per_frame_aligned_bump_allocator_unit verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // result side: stall pattern, plus one long hold-off to back the queue up
    initial begin
        int unsigned mode;
        int unsigned len;
        bit hold_done;
        hold_done = 0;
        wait (aresetn);
        forever begin
            if (hold_request && !hold_done) begin
                repeat (HOLD_CYCLES) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
                hold_done = 1;
            end else begin
                mode = $urandom_range(0, 3);
                len = $urandom_range(10, 60);
                repeat (len) begin
                    @(negedge aclk);
                    case (mode)
                        0: m_ready <= 1'b1;
                        1: m_ready <= 1'($urandom_range(0, 1));
                        2: m_ready <= ($urandom_range(0, 3) != 0);
                        default: m_ready <= ($urandom_range(0, 4) == 0);
                    endcase
                end
            end
        end
    end

    task automatic send_word(logic op, logic [IDX_W-1:0] idx, logic [SIZE_W-1:0] size,
                             logic [ALIGN_W-1:0] align);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_operation <= op;
        s_frame_index <= idx;
        s_request_size <= size;
        s_request_alignment <= align;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic idle_cycles(int unsigned n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_slice_size(logic [SIZE_W-1:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_bytes_per_frame <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly sane allocations sized against the slice, the rest noise
    task automatic send_random_word();
        logic [63:0] lim;
        int unsigned pick;
        logic op;
        logic [IDX_W-1:0] idx;
        logic [SIZE_W-1:0] size;
        logic [ALIGN_W-1:0] align;
        pick = $urandom_range(0, 99);
        op = OP_ALLOC;
        idx = IDX_W'($urandom_range(0, 3));
        size = SIZE_W'($urandom);
        align = ALIGN_W'($urandom_range(0, 2047));
        lim = sb.slice_bytes() / 8;
        if (lim == 0) lim = 64;
        if (pick < 10) begin
            op = OP_BEGIN;
        end else if (pick < 80) begin
            size = SIZE_W'($urandom_range(1, lim[31:0]));
            align = ALIGN_W'(1 << $urandom_range(0, 9));
        end else if (pick < 87) begin
            align = ALIGN_W'(1 << $urandom_range(0, 9));
        end else if (pick < 91) begin
            size = '0;
        end else if (pick >= 97) begin
            align = ($urandom_range(0, 1) != 0) ? ALIGN_W'(1024) : '0;
        end
        send_word(op, idx, size, align);
    endtask

    task automatic run_phase(logic [SIZE_W-1:0] cfg, int unsigned count);
        int unsigned n;
        int unsigned burst;
        write_slice_size(cfg);
        n = 0;
        while (n < count) begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && n < count) begin
                send_random_word();
                burst--;
                n++;
            end
            idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        end
        settle();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // not configured yet
        send_word(OP_ALLOC, 2'd0, 31'd16, 11'd16);
        send_word(OP_BEGIN, 2'd2, 31'd0, 11'd0);
        settle();

        write_slice_size(31'd1000);
        send_word(OP_ALLOC, 2'd0, 31'd0, 11'd8);
        send_word(OP_ALLOC, 2'd0, 31'd8, 11'd0);
        send_word(OP_ALLOC, 2'd0, 31'd8, 11'd3);
        send_word(OP_ALLOC, 2'd0, 31'd8, 11'd1024);
        send_word(OP_ALLOC, 2'd3, 31'd8, 11'h7FF);
        send_word(OP_BEGIN, 2'd1, 31'd0, 11'd0);
        send_word(OP_ALLOC, 2'd0, 31'd1, 11'd1);
        send_word(OP_ALLOC, 2'd0, 31'd100, 11'd512);
        send_word(OP_ALLOC, 2'd0, 31'd7, 11'd4);
        send_word(OP_ALLOC, 2'd0, 31'd600, 11'd1);
        send_word(OP_ALLOC, 2'd0, 31'h7FFF_FFFF, 11'd2);
        send_word(OP_ALLOC, 2'd0, 31'd405, 11'd1);
        send_word(OP_BEGIN, 2'd3, 31'd0, 11'd0);
        send_word(OP_ALLOC, 2'd0, 31'd1025, 11'd1);
        send_word(OP_BEGIN, 2'd0, 31'd0, 11'd0);
        send_word(OP_ALLOC, 2'd0, 31'd1024, 11'd512);
        settle();

        // oversized register, rewritten mid-frame
        write_slice_size(31'h7FFF_FFFF);
        send_word(OP_ALLOC, 2'd0, 31'h4000_0000, 11'd64);
        send_word(OP_BEGIN, 2'd2, 31'd0, 11'd0);
        send_word(OP_ALLOC, 2'd1, 31'h4000_0000, 11'd256);
        send_word(OP_ALLOC, 2'd0, 31'd1, 11'd1);
        settle();

        hold_request = 1;
        run_phase(SIZE_W'($urandom_range(1, 4096)), 100);
        run_phase(31'h4000_0000, 100);
        run_phase(31'd512, 100);
        run_phase(SIZE_W'($urandom), 100);
        run_phase(31'd0, 30);
        run_phase(SIZE_W'($urandom_range(513, 1 << 20)), 100);
        run_phase(31'h7FFF_FFFF, 100);

        if (sb.errors == 0)
            $display("per_frame_aligned_bump_allocator_unit verification clean");
        else
            $display("per_frame_aligned_bump_allocator_unit verification failed");
        $finish;
    end

endmodule
